>>> hw/rtl/mlsr_pkg.sv
// Shared types, constants and helper functions of the memory LCD section refresh block.
package mlsr_pkg;

    // Geometry of the section store
    localparam int LINE_PIXELS  = 320;
    localparam int STORE_LINES  = 80;
    localparam int SCREEN_LINES = 240;

    localparam int LINE_BYTES  = LINE_PIXELS / 8;
    localparam int STORE_BYTES = (LINE_PIXELS * STORE_LINES + 7) / 8;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int COL_W       = $clog2(LINE_BYTES);
    localparam int LIN_W       = 18;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [COL_W-1:0]  col_t;

    // Command bytes on the wire
    localparam logic [7:0] CMD_WRITE = 8'h80;
    localparam logic [7:0] CMD_VCOM  = 8'h40;
    localparam logic [7:0] CMD_CLEAR = 8'h20;
    localparam logic [7:0] FILL_BYTE = 8'hFF;

    // Operation codes carried in the input tuser
    typedef enum logic [2:0] {
        FN_WRITE   = 3'd0,
        FN_READ    = 3'd1,
        FN_FILL    = 3'd2,
        FN_CLEAR   = 3'd3,
        FN_REFRESH = 3'd4,
        FN_NEXT    = 3'd5
    } func_t;

    // Result kinds carried in the output tuser
    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_IDLE  = 2'd2
    } kind_t;

    // Transfer phases
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_CMD    = 3'd1,
        PH_ADDR   = 3'd2,
        PH_DATA   = 3'd3,
        PH_TRAIL  = 3'd4,
        PH_LADDR  = 3'd5,
        PH_FINAL  = 3'd6,
        PH_CLRCMD = 3'd7
    } phase_t;

    // Item control sequencer states
    typedef enum logic [1:0] {
        CTL_FILL   = 2'd0,
        CTL_IDLE   = 2'd1,
        CTL_ACCESS = 2'd2
    } ctl_t;

    // Request from the control logic to the store
    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        logic       fill_start;
        addr_t      addr;
        logic [7:0] wr_data;
    } store_req_t;

    // Reverse bit order for bytes sent LSB first
    function automatic logic [7:0] bit_rev(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[7-k] = v[k];
        end
        return r;
    endfunction

    // First screen line of a section; unknown sections act as section 0
    function automatic logic [7:0] sec_first(input logic [2:0] sec);
        logic [7:0] f;
        case (sec)
            3'd1:    f = 8'd41;
            3'd2:    f = 8'd42;
            3'd3:    f = 8'd101;
            3'd4:    f = 8'd181;
            default: f = 8'd1;
        endcase
        return f;
    endfunction

    // Store bytes sent for a section
    function automatic addr_t sec_bytes(input logic [2:0] sec);
        addr_t n;
        case (sec)
            3'd2:    n = ADDR_W'(LINE_PIXELS * 39 / 8);
            3'd3:    n = ADDR_W'(LINE_PIXELS * 75 / 8);
            default: n = ADDR_W'(LINE_PIXELS * 40 / 8);
        endcase
        return n;
    endfunction

endpackage

>>> hw/rtl/mlsr_store.sv
// Section store memory with a registered read and a white fill sweep.
module mlsr_store (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mlsr_pkg::store_req_t  req,
    output logic [7:0]            rd_data,
    output logic                  fill_busy
);

    logic [7:0]      mem [mlsr_pkg::STORE_BYTES];
    logic [7:0]      rd_data_reg;
    mlsr_pkg::addr_t fill_cnt_reg;
    mlsr_pkg::addr_t fill_cnt_next;
    logic            fill_busy_reg;
    logic            fill_busy_next;
    logic            fill_last;

    // Sweep control: start at reset or on request, stop after the last byte
    assign fill_last = (fill_cnt_reg == mlsr_pkg::ADDR_W'(mlsr_pkg::STORE_BYTES - 1));

    always_comb begin
        fill_cnt_next  = fill_cnt_reg;
        fill_busy_next = fill_busy_reg;
        if (req.fill_start) begin
            fill_cnt_next  = '0;
            fill_busy_next = 1'b1;
        end else if (fill_busy_reg) begin
            fill_cnt_next  = fill_cnt_reg + 1'b1;
            fill_busy_next = !fill_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_cnt_reg  <= '0;
            fill_busy_reg <= 1'b1;
        end else begin
            fill_cnt_reg  <= fill_cnt_next;
            fill_busy_reg <= fill_busy_next;
        end
    end

    // Write port: the sweep owns it while busy
    always_ff @(posedge aclk) begin
        if (fill_busy_reg) begin
            mem[fill_cnt_reg] <= mlsr_pkg::FILL_BYTE;
        end else if (req.wr_en) begin
            mem[req.addr] <= req.wr_data;
        end
    end

    // Read port: data registered, held until the next read
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data   = rd_data_reg;
    assign fill_busy = fill_busy_reg;

endmodule

>>> hw/rtl/memory_lcd_section_refresh_top.sv
// Top level of the memory LCD section refresh block: item control, transfer sequencer, output.
//
// Input channel (s_): one item per operation in s_tuser: write pixel, read pixel, fill white,
// start clear, start refresh, next byte. Pixel and section fields travel in s_tdata.
// Result channel (m_): a pixel read answer, a wire byte, or an idle notice; m_tuser gives
// its kind, m_tlast marks the last byte of a transfer.
// Each item is read from the store in the cycle it is accepted (CTL_IDLE); the modified byte is
// then written back, or the result loaded, in the access state (CTL_ACCESS), which holds while
// a result has nowhere to go. No new item is accepted until the access state is left. A loaded
// result is presented on m_ from the output register. A fill (fill white, or start clear
// while no transfer runs) sweeps all 3200 store bytes at one byte per cycle; no item is
// accepted until the sweep is done.
// After reset the same sweep paints the store white; s_tready rises once the sweep is done.
// VCOM starts at one and no transfer is active.
// A held output register keeps the last result while the receiver stalls; the next item
// is still accepted, and it waits in its write-back cycle only if it has a result of its
// own and the output register is still full.
module memory_lcd_section_refresh_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [8:0] pixel_x, [16:9] pixel_y, [17] pixel_color, [20:18] section_select, [23:21] zero
    input  logic [23:0] s_tdata,
    // [2:0] func
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] pixel_value, [8:1] wire_byte, [15:9] zero
    output logic [15:0] m_tdata,
    // [1:0] result_kind
    output logic [1:0]  m_tuser,
    // transfer_end
    output logic        m_tlast
);

    // Input field split
    logic [8:0] in_x;
    logic [7:0] in_y;
    logic       in_color;
    logic [2:0] in_sec;
    logic       accept;

    assign in_x     = s_tdata[8:0];
    assign in_y     = s_tdata[16:9];
    assign in_color = s_tdata[17];
    assign in_sec   = s_tdata[20:18];
    assign accept   = s_tvalid && s_tready;

    // Control state and item registers
    mlsr_pkg::ctl_t   ctl_reg, ctl_next;
    mlsr_pkg::func_t  func_reg;
    logic [2:0]       bit_reg;
    logic             color_reg;
    logic             range_reg;
    logic [2:0]       sec_reg;
    mlsr_pkg::addr_t  addr_reg;

    // Transfer state
    mlsr_pkg::phase_t phase_reg, phase_next;
    logic             vcom_reg, vcom_next;
    mlsr_pkg::addr_t  byte_idx_reg, byte_idx_next;
    mlsr_pkg::col_t   col_reg, col_next;
    logic [7:0]       line_addr_reg, line_addr_next;
    logic [7:0]       first_line_reg, first_line_next;
    mlsr_pkg::addr_t  byte_total_reg, byte_total_next;

    // Output register
    logic             out_valid_reg, out_valid_next;
    mlsr_pkg::kind_t  out_kind_reg;
    logic             out_pix_reg;
    logic [7:0]       out_byte_reg;
    logic             out_end_reg;

    // Store interface
    mlsr_pkg::store_req_t store_req;
    logic [7:0]           rd_data;
    logic                 fill_busy;

    // Access-cycle decisions
    logic            res_valid;
    mlsr_pkg::kind_t res_kind;
    logic            res_pix;
    logic [7:0]      res_byte;
    logic            res_end;
    logic            wr_want;
    logic [7:0]      wr_byte;
    logic            fill_want;
    logic            stall;
    logic            commit;

    // Pixel address and range check at accept
    logic [mlsr_pkg::LIN_W-1:0] pix_lin;
    mlsr_pkg::addr_t            pix_addr;
    logic                       pix_ok;
    mlsr_pkg::addr_t            rd_addr;

    assign pix_lin  = mlsr_pkg::LIN_W'(in_y) * mlsr_pkg::LIN_W'(mlsr_pkg::LINE_PIXELS)
                    + mlsr_pkg::LIN_W'(in_x);
    assign pix_addr = mlsr_pkg::ADDR_W'(pix_lin >> 3);
    assign pix_ok   = (int'(in_x) < mlsr_pkg::LINE_PIXELS)
                   && (int'(in_y) < mlsr_pkg::SCREEN_LINES)
                   && (int'(in_y) < mlsr_pkg::STORE_LINES);
    assign rd_addr  = (mlsr_pkg::func_t'(s_tuser) == mlsr_pkg::FN_NEXT) ? byte_idx_reg
                                                                         : pix_addr;

    // Capture the item
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg  <= mlsr_pkg::func_t'(s_tuser);
            bit_reg   <= in_x[2:0];
            color_reg <= in_color;
            range_reg <= pix_ok;
            sec_reg   <= in_sec;
            addr_reg  <= pix_addr;
        end
    end

    // Work out the item's effect from the byte read back
    always_comb begin
        res_valid       = 1'b0;
        res_kind        = mlsr_pkg::KIND_BYTE;
        res_pix         = 1'b0;
        res_byte        = '0;
        res_end         = 1'b0;
        wr_want         = 1'b0;
        wr_byte         = rd_data;
        fill_want       = 1'b0;
        phase_next      = phase_reg;
        vcom_next       = vcom_reg;
        byte_idx_next   = byte_idx_reg;
        col_next        = col_reg;
        line_addr_next  = line_addr_reg;
        first_line_next = first_line_reg;
        byte_total_next = byte_total_reg;
        case (func_reg)
            mlsr_pkg::FN_WRITE: begin
                wr_want          = range_reg;
                wr_byte[bit_reg] = color_reg;
            end
            mlsr_pkg::FN_READ: begin
                res_valid = 1'b1;
                res_kind  = mlsr_pkg::KIND_PIXEL;
                res_pix   = range_reg && rd_data[bit_reg];
            end
            mlsr_pkg::FN_FILL: begin
                fill_want = 1'b1;
            end
            mlsr_pkg::FN_CLEAR: begin
                if (phase_reg == mlsr_pkg::PH_IDLE) begin
                    fill_want  = 1'b1;
                    phase_next = mlsr_pkg::PH_CLRCMD;
                end
            end
            mlsr_pkg::FN_REFRESH: begin
                if (phase_reg == mlsr_pkg::PH_IDLE) begin
                    first_line_next = mlsr_pkg::sec_first(sec_reg);
                    line_addr_next  = mlsr_pkg::sec_first(sec_reg);
                    byte_total_next = mlsr_pkg::sec_bytes(sec_reg);
                    byte_idx_next   = '0;
                    col_next        = '0;
                    phase_next      = mlsr_pkg::PH_CMD;
                end
            end
            mlsr_pkg::FN_NEXT: begin
                res_valid = 1'b1;
                unique case (phase_reg)
                    mlsr_pkg::PH_IDLE: begin
                        res_kind = mlsr_pkg::KIND_IDLE;
                    end
                    mlsr_pkg::PH_CMD: begin
                        res_byte   = mlsr_pkg::CMD_WRITE | (vcom_reg ? mlsr_pkg::CMD_VCOM : 8'h00);
                        vcom_next  = !vcom_reg;
                        phase_next = mlsr_pkg::PH_ADDR;
                    end
                    mlsr_pkg::PH_ADDR: begin
                        res_byte   = mlsr_pkg::bit_rev(first_line_reg);
                        phase_next = (byte_idx_reg < byte_total_reg) ? mlsr_pkg::PH_DATA
                                                                     : mlsr_pkg::PH_FINAL;
                    end
                    mlsr_pkg::PH_DATA: begin
                        res_byte      = (int'(byte_idx_reg) < mlsr_pkg::STORE_BYTES)
                                      ? mlsr_pkg::bit_rev(rd_data) : 8'h00;
                        byte_idx_next = byte_idx_reg + 1'b1;
                        // advance the line at the end of each line's bytes
                        if (col_reg == mlsr_pkg::COL_W'(mlsr_pkg::LINE_BYTES - 1)) begin
                            col_next       = '0;
                            line_addr_next = line_addr_reg + 1'b1;
                            phase_next     = mlsr_pkg::PH_TRAIL;
                        end else begin
                            col_next   = col_reg + 1'b1;
                            phase_next = (byte_idx_next < byte_total_reg) ? mlsr_pkg::PH_DATA
                                                                          : mlsr_pkg::PH_FINAL;
                        end
                    end
                    mlsr_pkg::PH_TRAIL: begin
                        phase_next = mlsr_pkg::PH_LADDR;
                    end
                    mlsr_pkg::PH_LADDR: begin
                        res_byte   = mlsr_pkg::bit_rev(line_addr_reg);
                        phase_next = (byte_idx_reg < byte_total_reg) ? mlsr_pkg::PH_DATA
                                                                     : mlsr_pkg::PH_FINAL;
                    end
                    mlsr_pkg::PH_FINAL: begin
                        res_end    = 1'b1;
                        phase_next = mlsr_pkg::PH_IDLE;
                    end
                    mlsr_pkg::PH_CLRCMD: begin
                        res_byte   = mlsr_pkg::CMD_CLEAR | (vcom_reg ? mlsr_pkg::CMD_VCOM : 8'h00);
                        vcom_next  = !vcom_reg;
                        phase_next = mlsr_pkg::PH_FINAL;
                    end
                    default: begin
                        res_kind = mlsr_pkg::KIND_IDLE;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Hold the access cycle while a result has nowhere to go
    assign stall = res_valid && out_valid_reg && !m_tready;

    // Control sequencer: next state
    always_comb begin
        ctl_next = ctl_reg;
        unique case (ctl_reg)
            mlsr_pkg::CTL_FILL: begin
                if (!fill_busy) begin
                    ctl_next = mlsr_pkg::CTL_IDLE;
                end
            end
            mlsr_pkg::CTL_IDLE: begin
                if (s_tvalid) begin
                    ctl_next = mlsr_pkg::CTL_ACCESS;
                end
            end
            mlsr_pkg::CTL_ACCESS: begin
                if (!stall) begin
                    ctl_next = fill_want ? mlsr_pkg::CTL_FILL : mlsr_pkg::CTL_IDLE;
                end
            end
            default: begin
                ctl_next = mlsr_pkg::CTL_IDLE;
            end
        endcase
    end

    // Control sequencer: outputs
    always_comb begin
        s_tready             = 1'b0;
        commit               = 1'b0;
        store_req.rd_en      = 1'b0;
        store_req.wr_en      = 1'b0;
        store_req.fill_start = 1'b0;
        store_req.addr       = rd_addr;
        store_req.wr_data    = wr_byte;
        unique case (ctl_reg)
            mlsr_pkg::CTL_FILL: begin
            end
            mlsr_pkg::CTL_IDLE: begin
                s_tready        = 1'b1;
                store_req.rd_en = s_tvalid;
            end
            mlsr_pkg::CTL_ACCESS: begin
                commit               = !stall;
                store_req.addr       = addr_reg;
                store_req.wr_en      = !stall && wr_want;
                store_req.fill_start = !stall && fill_want;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= mlsr_pkg::CTL_FILL;
        end else begin
            ctl_reg <= ctl_next;
        end
    end

    // Advance the transfer state on commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= mlsr_pkg::PH_IDLE;
            vcom_reg       <= 1'b1;
            byte_idx_reg   <= '0;
            col_reg        <= '0;
            line_addr_reg  <= '0;
            first_line_reg <= '0;
            byte_total_reg <= '0;
        end else if (commit) begin
            phase_reg      <= phase_next;
            vcom_reg       <= vcom_next;
            byte_idx_reg   <= byte_idx_next;
            col_reg        <= col_next;
            line_addr_reg  <= line_addr_next;
            first_line_reg <= first_line_next;
            byte_total_reg <= byte_total_next;
        end
    end

    // Output register: load a result, drop it once taken
    assign out_valid_next = (commit && res_valid) ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit && res_valid) begin
            out_kind_reg <= res_kind;
            out_pix_reg  <= res_pix;
            out_byte_reg <= res_byte;
            out_end_reg  <= res_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_byte_reg, out_pix_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_end_reg;

    // Section store
    mlsr_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (store_req),
        .rd_data   (rd_data),
        .fill_busy (fill_busy)
    );

endmodule

>>> tb/sv/memory_lcd_section_refresh_top_tb.sv
// Self-checking testbench for the memory LCD section refresh block with its own predictor.
`timescale 1ns / 100ps

module memory_lcd_section_refresh_top_tb;
    import mlsr_pkg::*;

    // Operation codes with no effect on the block
    localparam logic [2:0] FN_UNUSED6 = 3'd6;
    localparam logic [2:0] FN_UNUSED7 = 3'd7;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 24;
    localparam int MAX_WAIT      = 13;
    localparam int RANDOM_ITEMS  = 900;
    localparam int BACKLOG_HOLD  = 300;

    typedef struct {
        kind_t      kind;
        logic       pix;
        logic [7:0] wbyte;
        logic       last;
    } lcd_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    memory_lcd_section_refresh_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Shadow copy of the block state
    logic [7:0] shadow_store [STORE_BYTES];
    logic       shadow_vcom;
    phase_t     shadow_phase;
    int         shadow_index;
    int         shadow_line;
    int         shadow_first;
    int         shadow_total;

    lcd_result_t pending_lcd_results [$];

    int  mismatch_count;
    int  cycle_count;
    int  items_sent;
    int  bytes_checked;
    int  answers_checked;
    int  idle_checked;
    int  transfers_seen;
    int  receiver_hold_cycles;
    bit  sender_gaps_on;
    bit  receiver_stalls_on;

    // Clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic logic [7:0] mirror_byte(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    function automatic bit pixel_in_store(input logic [8:0] px, input logic [7:0] py);
        return (int'(px) < LINE_PIXELS) && (int'(py) < SCREEN_LINES) && (int'(py) < STORE_LINES);
    endfunction

    // Screen line where a section starts; unknown sections fall back to section 0
    function automatic int section_start(input logic [2:0] sec);
        case (sec)
            3'd1:    return 41;
            3'd2:    return 42;
            3'd3:    return 101;
            3'd4:    return 181;
            default: return 1;
        endcase
    endfunction

    function automatic int section_lines(input logic [2:0] sec);
        case (sec)
            3'd2:    return 39;
            3'd3:    return 75;
            default: return 40;
        endcase
    endfunction

    task automatic whiten_shadow_store();
        foreach (shadow_store[i]) begin
            shadow_store[i] = FILL_BYTE;
        end
    endtask

    task automatic reset_shadow();
        whiten_shadow_store();
        shadow_vcom  = 1'b1;
        shadow_phase = PH_IDLE;
        shadow_index = 0;
        shadow_line  = 0;
        shadow_first = 0;
        shadow_total = 0;
    endtask

    // After a line address: more data, or the closing trailer
    task automatic pick_after_line();
        shadow_phase = (shadow_index < shadow_total) ? PH_DATA : PH_FINAL;
    endtask

    // Advance the shadow state by one item and queue the result it causes
    task automatic predict_lcd_response(input logic [2:0] fn, input logic [8:0] px,
                                        input logic [7:0] py, input logic pc,
                                        input logic [2:0] sec);
        lcd_result_t r;
        int          addr;
        int          cur;
        bit          has_result;
        r.kind     = KIND_BYTE;
        r.pix      = 1'b0;
        r.wbyte    = 8'h00;
        r.last     = 1'b0;
        has_result = 1'b0;
        addr       = (int'(py) * LINE_PIXELS + int'(px)) / 8;
        case (fn)
            FN_WRITE: begin
                if (pixel_in_store(px, py)) shadow_store[addr][px[2:0]] = pc;
            end
            FN_READ: begin
                has_result = 1'b1;
                r.kind     = KIND_PIXEL;
                if (pixel_in_store(px, py)) r.pix = shadow_store[addr][px[2:0]];
            end
            FN_FILL: whiten_shadow_store();
            FN_CLEAR: begin
                if (shadow_phase == PH_IDLE) begin
                    whiten_shadow_store();
                    shadow_phase = PH_CLRCMD;
                end
            end
            FN_REFRESH: begin
                if (shadow_phase == PH_IDLE) begin
                    shadow_first = section_start(sec);
                    shadow_line  = shadow_first;
                    shadow_total = LINE_PIXELS * section_lines(sec) / 8;
                    shadow_index = 0;
                    shadow_phase = PH_CMD;
                end
            end
            FN_NEXT: begin
                has_result = 1'b1;
                case (shadow_phase)
                    PH_CMD: begin
                        r.wbyte      = CMD_WRITE | (shadow_vcom ? CMD_VCOM : 8'h00);
                        shadow_vcom  = ~shadow_vcom;
                        shadow_phase = PH_ADDR;
                    end
                    PH_ADDR: begin
                        r.wbyte = mirror_byte(8'(shadow_first));
                        pick_after_line();
                    end
                    PH_DATA: begin
                        r.wbyte = mirror_byte(shadow_store[shadow_index]);
                        shadow_index++;
                        cur = shadow_index / LINE_BYTES + shadow_first;
                        if (cur != shadow_line) begin
                            shadow_line  = cur;
                            shadow_phase = PH_TRAIL;
                        end else begin
                            pick_after_line();
                        end
                    end
                    PH_TRAIL: shadow_phase = PH_LADDR;
                    PH_LADDR: begin
                        r.wbyte = mirror_byte(8'(shadow_line));
                        pick_after_line();
                    end
                    PH_FINAL: begin
                        r.last       = 1'b1;
                        shadow_phase = PH_IDLE;
                    end
                    PH_CLRCMD: begin
                        r.wbyte      = CMD_CLEAR | (shadow_vcom ? CMD_VCOM : 8'h00);
                        shadow_vcom  = ~shadow_vcom;
                        shadow_phase = PH_FINAL;
                    end
                    default: r.kind = KIND_IDLE;
                endcase
            end
            default: ;
        endcase
        if (has_result) pending_lcd_results.push_back(r);
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("[%0d] mismatch on %s: expected 0x%0h, got 0x%0h", cycle_count, what, want,
                 got);
        mismatch_count++;
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : check_results
        lcd_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_lcd_results.size() == 0) begin
                report_mismatch("unexpected result kind", 0, m_tuser);
            end else begin
                want = pending_lcd_results.pop_front();
                if (m_tuser != want.kind)      report_mismatch("result kind", want.kind, m_tuser);
                if (m_tdata[0] != want.pix)    report_mismatch("pixel value", want.pix, m_tdata[0]);
                if (m_tdata[8:1] != want.wbyte)
                    report_mismatch("wire byte", want.wbyte, m_tdata[8:1]);
                if (m_tlast != want.last)      report_mismatch("transfer end", want.last, m_tlast);
                case (want.kind)
                    KIND_PIXEL: answers_checked++;
                    KIND_BYTE:  bytes_checked++;
                    default:    idle_checked++;
                endcase
                if (want.last) transfers_seen++;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_lcd_results.size());
            $display("memory_lcd_section_refresh_top test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- result sink

    // Accept results with random stalls; a requested hold-off stalls one long stretch
    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (receiver_hold_cycles > 0) begin
                stall                = receiver_hold_cycles;
                receiver_hold_cycles = 0;
            end else begin
                stall = receiver_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ---------------------------------------------------------------- item driver

    // Offer one item, after a random gap when gaps are on, and predict it once accepted
    task automatic send_lcd_item(input logic [2:0] fn, input logic [8:0] px,
                                 input logic [7:0] py, input logic pc, input logic [2:0] sec);
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {3'b000, sec, pc, py, px};
        do @(posedge aclk); while (!s_tready);
        predict_lcd_response(fn, px, py, pc, sec);
        items_sent++;
    endtask

    // Hold the input until every expected result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_lcd_results.size() != 0);
    endtask

    task automatic redraw_idling();
        sender_gaps_on     = $urandom_range(0, 2) != 0;
        receiver_stalls_on = $urandom_range(0, 2) != 0;
    endtask

    function automatic logic [8:0] pick_column();
        if ($urandom_range(0, 99) < 85) return 9'($urandom_range(0, LINE_PIXELS - 1));
        return 9'($urandom_range(LINE_PIXELS, 511));
    endfunction

    function automatic logic [7:0] pick_row();
        if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, STORE_LINES - 1));
        return 8'($urandom_range(STORE_LINES, 255));
    endfunction

    task automatic send_pixel_op(input logic [2:0] fn);
        send_lcd_item(fn, pick_column(), pick_row(), 1'($urandom_range(0, 1)),
                      3'($urandom_range(0, 7)));
    endtask

    // ---------------------------------------------------------------- tests

    // Corners of the store, out-of-range pixels, idle advance, unused codes, fill
    task automatic test_pixel_access();
        send_lcd_item(FN_READ,    9'd0,   8'd0,   1'b0, 3'd0);
        send_lcd_item(FN_WRITE,   9'd0,   8'd0,   1'b0, 3'd0);
        send_lcd_item(FN_READ,    9'd0,   8'd0,   1'b0, 3'd0);
        send_lcd_item(FN_WRITE,   9'd319, 8'd79,  1'b0, 3'd7);
        send_lcd_item(FN_READ,    9'd319, 8'd79,  1'b0, 3'd0);
        send_lcd_item(FN_WRITE,   9'd320, 8'd0,   1'b0, 3'd0);
        send_lcd_item(FN_READ,    9'd320, 8'd0,   1'b0, 3'd0);
        send_lcd_item(FN_WRITE,   9'd511, 8'd255, 1'b0, 3'd7);
        send_lcd_item(FN_READ,    9'd511, 8'd255, 1'b1, 3'd7);
        send_lcd_item(FN_WRITE,   9'd5,   8'd80,  1'b0, 3'd0);
        send_lcd_item(FN_READ,    9'd5,   8'd240, 1'b0, 3'd0);
        send_lcd_item(FN_NEXT,    9'd0,   8'd0,   1'b0, 3'd0);
        send_lcd_item(FN_UNUSED6, 9'd1,   8'd1,   1'b1, 3'd1);
        send_lcd_item(FN_UNUSED7, 9'd2,   8'd2,   1'b0, 3'd2);
        send_lcd_item(FN_FILL,    9'd0,   8'd0,   1'b0, 3'd0);
        send_lcd_item(FN_READ,    9'd319, 8'd79,  1'b0, 3'd0);
        wait_drained();
    endtask

    // Clear transfer, with a second clear and a refresh ignored while it runs
    task automatic test_clear_transfer();
        send_lcd_item(FN_CLEAR,   9'd0, 8'd0, 1'b0, 3'd0);
        send_lcd_item(FN_WRITE,   9'd7, 8'd3, 1'b0, 3'd0);
        send_lcd_item(FN_CLEAR,   9'd0, 8'd0, 1'b0, 3'd0);
        send_lcd_item(FN_REFRESH, 9'd0, 8'd0, 1'b0, 3'd4);
        send_lcd_item(FN_NEXT,    9'd0, 8'd0, 1'b0, 3'd0);
        send_lcd_item(FN_READ,    9'd7, 8'd3, 1'b0, 3'd0);
        send_lcd_item(FN_NEXT,    9'd0, 8'd0, 1'b0, 3'd0);
        send_lcd_item(FN_NEXT,    9'd0, 8'd0, 1'b0, 3'd0);
        wait_drained();
    endtask

    // Run one refresh to its end, touching the store while bytes go out
    task automatic test_full_refresh();
        logic [2:0] sec;
        int         pick;
        sec = 3'($urandom_range(0, 7));
        if (sec == 3'd3) sec = 3'd2;
        send_lcd_item(FN_REFRESH, 9'd0, 8'd0, 1'b0, sec);
        while (shadow_phase != PH_IDLE) begin
            if ($urandom_range(0, 149) == 0) redraw_idling();
            pick = $urandom_range(0, 99);
            if (pick < 8)       send_pixel_op(FN_WRITE);
            else if (pick < 12) send_pixel_op(FN_READ);
            else if (pick < 13) send_lcd_item(FN_REFRESH, 9'd0, 8'd0, 1'b0,
                                              3'($urandom_range(0, 7)));
            else                send_lcd_item(FN_NEXT, 9'd0, 8'd0, 1'b0, 3'd0);
        end
        wait_drained();
    endtask

    // Stall the receiver for a long stretch while items keep coming back to back
    task automatic test_output_backpressure();
        sender_gaps_on       = 1'b0;
        receiver_hold_cycles = BACKLOG_HOLD;
        send_lcd_item(FN_READ, 9'd0, 8'd0, 1'b0, 3'd0);
        for (int i = 0; i < 40; i++) begin
            case ($urandom_range(0, 2))
                0:       send_pixel_op(FN_READ);
                1:       send_lcd_item(FN_NEXT, 9'd0, 8'd0, 1'b0, 3'd0);
                default: send_pixel_op(FN_WRITE);
            endcase
        end
        wait_drained();
    endtask

    // Bursts of pixel traffic and byte advances, transfer starts, fills, and some noise
    task automatic test_random_mix();
        int start_count;
        int pick;
        int burst;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) redraw_idling();
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                burst = $urandom_range(3, 15);
                repeat (burst) send_pixel_op(($urandom_range(0, 9) < 6) ? FN_WRITE : FN_READ);
            end else if (pick < 70) begin
                burst = $urandom_range(10, 80);
                repeat (burst) send_lcd_item(FN_NEXT, 9'd0, 8'd0, 1'b0, 3'd0);
            end else if (pick < 80) begin
                send_lcd_item(FN_REFRESH, 9'd0, 8'd0, 1'b0, 3'($urandom_range(0, 7)));
            end else if (pick < 86) begin
                send_lcd_item(FN_CLEAR, 9'd0, 8'd0, 1'b0, 3'd0);
                burst = $urandom_range(1, 4);
                repeat (burst) send_lcd_item(FN_NEXT, 9'd0, 8'd0, 1'b0, 3'd0);
            end else if (pick < 89) begin
                send_lcd_item(FN_FILL, 9'd0, 8'd0, 1'b0, 3'd0);
            end else begin
                send_lcd_item(3'($urandom_range(0, 7)), 9'($urandom_range(0, 511)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              3'($urandom_range(0, 7)));
            end
        end
        wait_drained();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        mismatch_count       = 0;
        items_sent           = 0;
        bytes_checked        = 0;
        answers_checked      = 0;
        idle_checked         = 0;
        transfers_seen       = 0;
        receiver_hold_cycles = 0;
        sender_gaps_on       = 1'b1;
        receiver_stalls_on   = 1'b1;
        reset_shadow();
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= FN_WRITE;
        aresetn  <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_pixel_access();
        test_clear_transfer();
        test_full_refresh();
        test_output_backpressure();
        redraw_idling();
        test_random_mix();

        // Let any stray result show up before closing
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_lcd_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_lcd_results.size());

        $display("run covered %0d items: %0d wire bytes, %0d completed transfers,",
                 items_sent, bytes_checked, transfers_seen);
        $display("%0d pixel answers and %0d idle notices, %0d mismatches, %0d cycles",
                 answers_checked, idle_checked, mismatch_count, cycle_count);
        if (mismatch_count == 0) begin
            $display("memory_lcd_section_refresh_top test passed");
        end else begin
            $display("memory_lcd_section_refresh_top test failed");
        end
        $finish;
    end

endmodule
